/* hdl/phase_drift_sync_classifier_unit_assert.svh */
// Assertion macros shared by the checker of the phase drift classifier.
`ifndef PHASE_DRIFT_SYNC_CLASSIFIER_UNIT_ASSERT_SVH
`define PHASE_DRIFT_SYNC_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define PDSC_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("pdsc assertion failed");

// Next-cycle implication, disabled while dis is high.
`define PDSC_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("pdsc assertion failed");

`endif

/* hdl/pdsc_pkg.sv */
// Shared types, codes and reset constants of the phase drift classifier.
package pdsc_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int STAMP_W  = 16;
  localparam int PHASE_W  = 16;
  localparam int DRIFT_W  = 15;
  localparam int IDLE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] MODE_REF  = 2'd0;
  localparam logic [1:0] MODE_SYNC = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_SYNC_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd3;

  localparam logic [14:0] IN_SYNC_LIMIT_RST = 15'd20;
  localparam logic [14:0] FAST_LIMIT_RST    = 15'd90;
  localparam logic [15:0] SLOW_LIMIT_RST    = 16'hFFA6;  // -90
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd3000;

  localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_NO_SIGNAL = 3'd0,
    ST_TOO_SLOW  = 3'd1,
    ST_SLOW      = 3'd2,
    ST_IN_SYNC   = 3'd3,
    ST_FAST      = 3'd4,
    ST_TOO_FAST  = 3'd5
  } status_t;

  typedef struct packed {
    logic [14:0] in_sync_limit;
    logic [14:0] fast_limit;
    logic [15:0] slow_limit;     // two's complement
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t              status;
    logic [DRIFT_W-1:0]   drift;
    logic [PHASE_W-1:0]   phase;
  } result_t;

endpackage

/* hdl/phase_drift_sync_classifier_unit.sv */
// Top level of the phase drift classifier: input and result registers.
//
// Input channel (in_valid/in_ready, mode, stamp): one beat per event. A
// reference edge stores its timer capture, a sync edge produces one result
// beat, a tick advances the idle counter. Mode 3 is dropped silently.
// Result channel (out_valid/out_ready, status, drift, phase): one beat per
// sync edge, in input order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready, a beat writes one register; unknown indexes are ignored.
// Path: a sync beat accepted into the input register moves on to the result
// register once the result register has room.
// Throughput: one beat per cycle on the input while no sync beat is held,
// set by the single pass of subtract, halve and compare between the registers.
// Stall: while a result waits for out_ready, reference and tick beats keep
// flowing; a second sync beat holds in the input register, and in_ready
// drops only once that register is held too.
// Reset (rst, synchronous): both registers empty, state cleared, limits back
// to their defaults.
module phase_drift_sync_classifier_unit #(
  parameter int TIMER_BITS = pdsc_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      mode,
  input  logic [pdsc_pkg::STAMP_W-1:0]    stamp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [pdsc_pkg::DRIFT_W-1:0]    drift,
  output logic [pdsc_pkg::PHASE_W-1:0]    phase,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdsc_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic               s1_valid;
  logic [1:0]         s1_mode;
  logic [STAMP_W-1:0] s1_stamp;
  logic               s1_sync;
  logic               advance;

  assign cfg_ready = 1'b1;

  pdsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdsc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (advance),
    .mode  (s1_mode),
    .stamp (s1_stamp),
    .res   (res)
  );

  // Only sync beats need room in the result register.
  assign s1_sync  = (s1_mode == MODE_SYNC);
  assign advance  = s1_valid && (!s1_sync || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode  <= mode;
      s1_stamp <= stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_sync) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_sync) begin
      status <= res.status;
      drift  <= res.drift;
      phase  <= res.phase;
    end
  end

endmodule

/* hdl/pdsc_cfg_regs.sv */
// Configuration register file of the phase drift classifier.
module pdsc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [pdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output pdsc_pkg::cfg_t                  cfg
);
  import pdsc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_sync_limit <= IN_SYNC_LIMIT_RST;
      cfg.fast_limit    <= FAST_LIMIT_RST;
      cfg.slow_limit    <= SLOW_LIMIT_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_SYNC_LIMIT: cfg.in_sync_limit <= cfg_data[14:0];
        REG_FAST_LIMIT:    cfg.fast_limit    <= cfg_data[14:0];
        REG_SLOW_LIMIT:    cfg.slow_limit    <= cfg_data;
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

endmodule

/* hdl/pdsc_core.sv */
// Phase state, drift arithmetic and status classification for one beat.
module pdsc_core #(
  parameter int TIMER_BITS = pdsc_pkg::TIMER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pdsc_pkg::cfg_t               cfg,
  input  logic                         fire,
  input  logic [1:0]                   mode,
  input  logic [pdsc_pkg::STAMP_W-1:0] stamp,
  output pdsc_pkg::result_t            res
);
  import pdsc_pkg::*;

  localparam int TB = TIMER_BITS;
  localparam int HW = (TB > 16) ? TB : 16;
  localparam logic signed [HW-1:0] H_MAX = HW'(16383);
  localparam logic signed [HW-1:0] H_MIN = -HW'(16384);

  logic [TB-1:0]     ref_stamp;
  logic [TB-1:0]     prev_phase;
  logic              ref_seen;
  logic [IDLE_W-1:0] idle_ticks;

  logic [TB-1:0]            stamp_t;
  logic [TB-1:0]            phase_cur;
  logic [TB-1:0]            wd;
  logic [TB-1:0]            hsum;
  logic [TB-1:0]            h;
  logic signed [HW-1:0]     hx;
  logic [DRIFT_W-1:0]       d;
  logic signed [15:0]       d16;
  logic [15:0]              mag;
  status_t                  cls;
  logic [IDLE_W-1:0]        idle_inc;

  assign stamp_t   = TB'(stamp);
  assign phase_cur = stamp_t - ref_stamp;
  assign wd        = phase_cur - prev_phase;

  // Halve toward zero: add one to negative values, then shift arithmetically.
  assign hsum = wd + TB'(wd[TB-1]);
  assign h    = {hsum[TB-1], hsum[TB-1:1]};
  assign hx   = HW'($signed(h));

  always_comb begin
    if (hx > H_MAX) begin
      d = 15'h3FFF;
    end else if (hx < H_MIN) begin
      d = 15'h4000;
    end else begin
      d = hx[DRIFT_W-1:0];
    end
  end

  assign d16 = 16'($signed(d));
  assign mag = d[DRIFT_W-1] ? (16'd0 - d16) : d16;

  // In-sync test first, then the positive side, then the negative side.
  always_comb begin
    if (mag <= {1'b0, cfg.in_sync_limit}) begin
      cls = ST_IN_SYNC;
    end else if (d16 > $signed({1'b0, cfg.fast_limit})) begin
      cls = ST_TOO_FAST;
    end else if (d16 > $signed({1'b0, cfg.in_sync_limit})) begin
      cls = ST_FAST;
    end else if (d16 < $signed(cfg.slow_limit)) begin
      cls = ST_TOO_SLOW;
    end else begin
      cls = ST_SLOW;
    end
  end

  assign res.status = ref_seen ? cls : ST_NO_SIGNAL;
  assign res.drift  = d;
  assign res.phase  = PHASE_W'(phase_cur);

  assign idle_inc = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_stamp  <= '0;
      prev_phase <= '0;
      ref_seen   <= 1'b0;
      idle_ticks <= '0;
    end else if (fire) begin
      case (mode)
        MODE_REF: begin
          ref_stamp <= stamp_t;
          ref_seen  <= 1'b1;
        end
        MODE_SYNC: begin
          prev_phase <= phase_cur;
          idle_ticks <= '0;
        end
        MODE_TICK: begin
          idle_ticks <= idle_inc;
          if (idle_inc > cfg.timeout_ticks) begin
            ref_seen <= 1'b0;
          end
        end
        default: ;  // unused mode: no state change
      endcase
    end
  end

endmodule

/* hdl/pdsc_checker.sv */
// Port-level checker of the phase drift classifier, bound to the top level.
`include "phase_drift_sync_classifier_unit_assert.svh"

module pdsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      status,
  input logic [pdsc_pkg::DRIFT_W-1:0]    drift,
  input logic [pdsc_pkg::PHASE_W-1:0]    phase
);
  import pdsc_pkg::*;

  // Hold a stalled result beat.
  `PDSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(drift) && $stable(phase))

  // After reset both registers are empty.
  `PDSC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid && in_ready)

  // Slow side is reached only with negative drift.
  `PDSC_ASSERT_NOW(a_slow_sign, clk, rst,
    out_valid && (status == ST_SLOW || status == ST_TOO_SLOW), drift[DRIFT_W-1])

  // Fast side is reached only with positive drift.
  `PDSC_ASSERT_NOW(a_fast_sign, clk, rst,
    out_valid && (status == ST_FAST || status == ST_TOO_FAST),
    !drift[DRIFT_W-1] && (drift != '0))

endmodule

bind phase_drift_sync_classifier_unit pdsc_checker u_pdsc_checker (.*);
